@@ hw/rtl/psdd_pkg.sv @@
// Shared types and constants for the packed sample delta decoder.
// Used by the decode core, the result FIFO, the top level and the testbench.
package psdd_pkg;

   localparam int unsigned CountWidth     = 32;
   localparam int unsigned CsrIndexWidth  = 1;
   localparam int unsigned CsrDataWidth   = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_WIDE_MODE    = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SAMPLE_COUNT = 1'd1;

   localparam int unsigned FifoDepth      = 4;
   localparam int unsigned FifoPtrWidth   = 2;
   localparam int unsigned FifoCountWidth = 3;

   localparam logic [7:0] RUN_START   = 8'd8;
   localparam logic [7:0] RUN_STEP    = 8'd16;
   localparam logic [7:0] INVERT_MASK = 8'hff;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       start_flag;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0] sample_low;
      logic [7:0] sample_high;
      logic       final_sample;
      logic       last_of_item;
   } rsp_type;

   // Results produced by one decoded byte: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ hw/rtl/psdd_intf.sv @@
// Valid/ready channel interfaces for packed bytes and decoded samples.
// Depends on nothing; payload widths follow the decoder's field list.
interface psdd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       start_flag;
   logic       end_of_data;

   modport source (output valid, output packed_byte, output start_flag,
                   output end_of_data, input ready);
   modport sink (input valid, input packed_byte, input start_flag,
                 input end_of_data, output ready);
endinterface

interface psdd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_low;
   logic [7:0] sample_high;
   logic       final_sample;
   logic       last_of_item;

   modport source (output valid, output sample_low, output sample_high,
                   output final_sample, output last_of_item, input ready);
   modport sink (input valid, input sample_low, input sample_high,
                 input final_sample, input last_of_item, output ready);
endinterface

@@ hw/rtl/psdd_core.sv @@
// Decode core: holds the bit-level decoder state and, while the FIFO has room,
// decodes one packed byte per cycle in eight bit steps. Depends on psdd_pkg.
module psdd_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  psdd_pkg::req_type                 in_item,
   input  logic                              fifo_space,
   input  logic                              wide_mode,
   input  logic [psdd_pkg::CountWidth-1:0]   sample_count,
   output logic                              in_take,
   output psdd_pkg::push_type                push
);

   typedef enum logic [2:0] {
      PH_LEAD, PH_LOW, PH_SIGN, PH_FLAG, PH_SHORT, PH_RUN, PH_NIB, PH_STOP
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [3:0]                       bits_left_ff, bits_left_in;
   logic [7:0]                       partial_ff, partial_in;
   logic                             sign_ff, sign_in;
   logic [7:0]                       run_ff, run_in;
   logic [7:0]                       low_ff, low_in;
   logic [7:0]                       delta_ff, delta_in;
   logic [psdd_pkg::CountWidth-1:0]  done_ff, done_in;
   logic [1:0]                       nres;
   psdd_pkg::rsp_type                res0, res1;

   assign in_take = in_valid && fifo_space;

   always_comb begin : decode
      phase_type                       ph;
      logic [3:0]                      bl;
      logic [7:0]                      part;
      logic [7:0]                      run;
      logic [7:0]                      low;
      logic [7:0]                      delta;
      logic                            sgn;
      logic [1:0]                      cnt;
      logic [psdd_pkg::CountWidth-1:0] sd;
      logic [psdd_pkg::CountWidth:0]   sd_ext;
      logic [psdd_pkg::CountWidth:0]   sc_ext;
      logic [3:0]                      stop_at;
      logic [1:0]                      fin_at;
      logic                            bitv;
      logic [3:0]                      width;
      logic                            take_bit;
      logic                            do_finish;
      logic [7:0]                      value;
      psdd_pkg::rsp_type               r;

      ph    = phase_ff;
      bl    = bits_left_ff;
      part  = partial_ff;
      run   = run_ff;
      low   = low_ff;
      delta = delta_ff;
      sgn   = sign_ff;
      sd    = done_ff;
      cnt   = 2'd0;
      res0  = '0;
      res1  = '0;
      r     = '0;

      // A start byte clears the decoder before its bits are used.
      if (in_item.start_flag) begin
         ph    = PH_LEAD;
         bl    = 4'd0;
         part  = 8'd0;
         run   = psdd_pkg::RUN_START;
         low   = 8'd0;
         delta = 8'd0;
         sgn   = 1'b0;
         sd    = '0;
      end

      // Count limits for zero, one and two samples already finished in this byte.
      sd_ext     = {1'b0, sd};
      sc_ext     = {1'b0, sample_count};
      stop_at[0] = sd_ext >= sc_ext;
      stop_at[1] = (sd_ext + 33'd1) >= sc_ext;
      stop_at[2] = (sd_ext + 33'd2) >= sc_ext;
      stop_at[3] = 1'b1;
      fin_at[0]  = (sd_ext + 33'd1) == sc_ext;
      fin_at[1]  = (sd_ext + 33'd2) == sc_ext;

      for (int k = 0; k < 8; k++) begin
         bitv      = in_item.packed_byte[k];
         width     = 4'd0;
         take_bit  = 1'b0;
         do_finish = 1'b0;
         value     = 8'd0;
         if (ph != PH_STOP && !stop_at[cnt]) begin
            if (ph == PH_LEAD) begin
               part = 8'd0;
               if (wide_mode) begin
                  ph = PH_LOW;
                  bl = 4'd8;
               end else begin
                  ph = PH_SIGN;
               end
            end
            case (ph)
               PH_LOW: begin
                  take_bit = 1'b1;
                  width    = 4'd8;
               end
               PH_SIGN: begin
                  sgn = bitv;
                  ph  = PH_FLAG;
               end
               PH_FLAG: begin
                  part = 8'd0;
                  if (bitv) begin
                     ph = PH_SHORT;
                     bl = 4'd3;
                  end else begin
                     ph  = PH_RUN;
                     run = psdd_pkg::RUN_START;
                  end
               end
               PH_SHORT: begin
                  take_bit = 1'b1;
                  width    = 4'd3;
               end
               PH_RUN: begin
                  if (bitv) begin
                     ph   = PH_NIB;
                     bl   = 4'd4;
                     part = 8'd0;
                  end else begin
                     run = run + psdd_pkg::RUN_STEP;
                  end
               end
               PH_NIB: begin
                  take_bit = 1'b1;
                  width    = 4'd4;
               end
               default: begin
               end
            endcase

            // Shared field shifter: bits land least significant first.
            if (take_bit) begin
               part = part | (8'(bitv) << 3'(width - bl));
               if (bl != 4'd0) begin
                  bl = bl - 4'd1;
               end
               if (bl == 4'd0) begin
                  case (ph)
                     PH_LOW: begin
                        low  = part;
                        part = 8'd0;
                        ph   = PH_SIGN;
                     end
                     PH_SHORT: begin
                        do_finish = 1'b1;
                        value     = part;
                     end
                     PH_NIB: begin
                        do_finish = 1'b1;
                        value     = run + part;
                     end
                     default: begin
                     end
                  endcase
               end
            end

            if (do_finish) begin
               if (sgn) begin
                  value = value ^ psdd_pkg::INVERT_MASK;
               end
               delta = delta + value;
               if (wide_mode) begin
                  r.sample_low  = low;
                  r.sample_high = delta;
               end else begin
                  r.sample_low  = delta;
                  r.sample_high = 8'd0;
               end
               r.final_sample = fin_at[cnt[0]];
               r.last_of_item = 1'b0;
               if (cnt == 2'd0) begin
                  res0 = r;
               end else begin
                  res1 = r;
               end
               cnt  = cnt + 2'd1;
               part = 8'd0;
               bl   = 4'd0;
               sgn  = 1'b0;
               run  = psdd_pkg::RUN_START;
               ph   = PH_LEAD;
            end
         end
      end

      if (in_item.end_of_data) begin
         ph = PH_STOP;
      end
      if (cnt == 2'd1) begin
         res0.last_of_item = 1'b1;
      end
      if (cnt == 2'd2) begin
         res1.last_of_item = 1'b1;
      end

      phase_in     = ph;
      bits_left_in = bl;
      partial_in   = part;
      sign_in      = sgn;
      run_in       = run;
      low_in       = low;
      delta_in     = delta;
      done_in      = sd + psdd_pkg::CountWidth'(cnt);
      nres         = cnt;
   end

   always_comb begin
      push.count  = in_take ? nres : 2'd0;
      push.first  = res0;
      push.second = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         bits_left_ff <= 4'd0;
         partial_ff   <= 8'd0;
         sign_ff      <= 1'b0;
         run_ff       <= psdd_pkg::RUN_START;
         low_ff       <= 8'd0;
         delta_ff     <= 8'd0;
         done_ff      <= '0;
      end else if (in_take) begin
         phase_ff     <= phase_in;
         bits_left_ff <= bits_left_in;
         partial_ff   <= partial_in;
         sign_ff      <= sign_in;
         run_ff       <= run_in;
         low_ff       <= low_in;
         delta_ff     <= delta_in;
         done_ff      <= done_in;
      end
   end

endmodule

@@ hw/rtl/psdd_rsp_fifo.sv @@
// Result FIFO: takes up to two decoded samples per cycle, hands out one
// while out_ready is high. Depends on psdd_pkg.
module psdd_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  psdd_pkg::push_type push,
   output logic               space,
   output logic               out_valid,
   input  logic               out_ready,
   output psdd_pkg::rsp_type  out_data
);

   psdd_pkg::rsp_type                    entries_ff [psdd_pkg::FifoDepth];
   logic [psdd_pkg::FifoPtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [psdd_pkg::FifoPtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [psdd_pkg::FifoCountWidth-1:0]  count_ff, count_in;
   logic                                 pop;

   // Room for two results is required before a byte is decoded.
   assign space     = count_ff <= psdd_pkg::FifoCountWidth'(psdd_pkg::FifoDepth - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + psdd_pkg::FifoPtrWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + psdd_pkg::FifoPtrWidth'(pop);
      count_in  = count_ff + psdd_pkg::FifoCountWidth'(push.count)
                  - psdd_pkg::FifoCountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + psdd_pkg::FifoPtrWidth'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/packed_sample_delta_decoder.sv @@
// A byte accepted on req_chan waits in the input register, is decoded into the
// result FIFO once the FIFO has room, and its first sample is then offered on rsp_chan.
// It takes one packed byte per cycle while the FIFO has room for two samples, and
// drains one sample per cycle while rsp_chan is ready, one transfer per sample.
// Reset (synchronous, active high) clears the configuration registers to zero,
// puts the decoder into a fresh block and empties the input and result stages.
//
// Structure: an input register holds the accepted byte; the decode core runs
// the eight bit steps of that byte against its decoder state combinationally and
// pushes zero, one or two samples into a four-entry result FIFO. The input
// register is refilled in the same cycle it is decoded, so back-to-back
// transactions flow as long as the FIFO has room for two more samples.
module packed_sample_delta_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   psdd_req_if.sink                              req_chan,
   psdd_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [psdd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [psdd_pkg::CsrDataWidth-1:0]     csr_write_data
);

   // Configuration registers: write only while the block is idle; it does not check.
   logic                              wide_mode_ff;
   logic [psdd_pkg::CountWidth-1:0]   sample_count_ff;

   // Input stage: one accepted transaction waiting to be decoded.
   logic                              in_valid_ff;
   psdd_pkg::req_type                 in_item_ff;

   logic                              in_take;
   logic                              fifo_space;
   psdd_pkg::push_type                push;
   psdd_pkg::rsp_type                 rsp_data;
   logic                              req_fire;

   // The input register may take a new transaction when it is empty or is
   // being decoded in this very cycle.
   assign req_chan.ready = !in_valid_ff || in_take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff    <= 1'b0;
         sample_count_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            psdd_pkg::CSR_WIDE_MODE: begin
               wide_mode_ff <= csr_write_data[0];
            end
            psdd_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_ff <= csr_write_data[psdd_pkg::CountWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   // The payload register needs no reset; it is only used behind in_valid_ff.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.packed_byte <= req_chan.packed_byte;
         in_item_ff.start_flag  <= req_chan.start_flag;
         in_item_ff.end_of_data <= req_chan.end_of_data;
      end
   end

   psdd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .in_item      (in_item_ff),
      .fifo_space   (fifo_space),
      .wide_mode    (wide_mode_ff),
      .sample_count (sample_count_ff),
      .in_take      (in_take),
      .push         (push)
   );

   psdd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (fifo_space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.sample_low   = rsp_data.sample_low;
   assign rsp_chan.sample_high  = rsp_data.sample_high;
   assign rsp_chan.final_sample = rsp_data.final_sample;
   assign rsp_chan.last_of_item = rsp_data.last_of_item;

endmodule

@@ hw/rtl/psdd_checker.sv @@
// Port-level checks for the packed sample delta decoder, bound to its top level.
// Depends on packed_sample_delta_decoder and the channel interfaces.
module psdd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_sample_low,
   input logic [7:0] rsp_sample_high,
   input logic       rsp_final_sample,
   input logic       rsp_last_of_item
);

   // Reset empties both stages: nothing is offered and input is taken.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("outputs not idle after reset");

   // The sample that reaches the count stops decoding, so it ends its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_sample |-> rsp_last_of_item)
      else $error("final sample not marked as last of its byte");

   // A stalled result stays offered with the same contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_low)
         && $stable(rsp_sample_high) && $stable(rsp_final_sample)
         && $stable(rsp_last_of_item))
      else $error("stalled result changed or dropped");

endmodule

bind packed_sample_delta_decoder psdd_checker u_psdd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sample_low   (rsp_chan.sample_low),
   .rsp_sample_high  (rsp_chan.sample_high),
   .rsp_final_sample (rsp_chan.final_sample),
   .rsp_last_of_item (rsp_chan.last_of_item)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for packed_sample_delta_decoder: a directed table, then random blocks.
// Depends on psdd_pkg, the psdd_req_if and psdd_rsp_if interfaces, and the decoder top level.
module tb;

   // The testbench gives up after StallLimit cycles without any transaction.
   // The slowest correct stretch is the deliberate receiver hold-off.
   localparam int StallLimit    = 1000;
   localparam int HoldOffCycles = 80;
   localparam int ItemTarget    = 1900;
   localparam int QuietFrom     = 1650;
   localparam int DirectedRows  = 23;

   // Bit-level decode steps of the sample code, in the order a code is read.
   typedef enum logic [2:0] {
      DS_LEAD, DS_LOW_BYTE, DS_SIGN, DS_FLAG, DS_SHORT, DS_RUN, DS_NIBBLE, DS_STOPPED
   } decode_step_type;

   // One row of the directed table: the register setting it needs, the packed byte,
   // and, where the samples are obvious, the samples typed in by hand.
   typedef struct {
      logic              wide;
      logic [31:0]       count;
      psdd_pkg::req_type item;
      bit                typed;
      int                n;
      psdd_pkg::rsp_type first;
      psdd_pkg::rsp_type second;
   } directed_row_type;

   localparam psdd_pkg::rsp_type NO_SAMPLE = '0;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_write_en;
   logic [psdd_pkg::CsrIndexWidth-1:0] csr_index;
   logic [psdd_pkg::CsrDataWidth-1:0]  csr_write_data;

   psdd_req_if req_if ();
   psdd_rsp_if rsp_if ();

   packed_sample_delta_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #6 clock = ~clock;

   // Register copies and decoder state, kept in step with every accepted transaction.
   logic            cfg_wide;
   logic [31:0]     cfg_count;
   decode_step_type dec_step;
   logic [3:0]      dec_bits_left;
   logic [7:0]      dec_field;
   logic            dec_sign;
   logic [7:0]      dec_run;
   logic [7:0]      dec_low_hold;
   logic [7:0]      dec_delta;
   logic [31:0]     dec_done;

   psdd_pkg::rsp_type fresh_samples[$];    // samples caused by the byte just decoded
   psdd_pkg::rsp_type awaited_samples[$];  // samples the decoder still owes us, oldest first

   int  mismatch_count   = 0;
   int  samples_checked  = 0;
   int  live_bytes       = 0;
   int  bytes_offered    = 0;
   int  settings_written = 0;
   int  held_cycles      = 0;
   bit  gaps_on          = 1'b0;
   bit  hold_off_request = 1'b0;

   // Hand-checked rows cover the reset setting, the sample count being reached,
   // a start byte that also carries the end mark, sign inversion with wrap of the
   // running delta, and the raw low byte of the wide layout. The other rows
   // (long zero runs that wrap the run value, two samples from one byte, the
   // largest count) take their samples from the predictor.
   directed_row_type directed_rows [DirectedRows] = '{
      '{1'b0, 32'd0,          '{8'hFF, 1'b0, 1'b0}, 1'b1, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'h5E, 1'b1, 1'b0}, 1'b1, 1, '{8'h07, 8'h00, 1'b0, 1'b1},
        NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'h00, 1'b0, 1'b0}, 1'b1, 1, '{8'h07, 8'h00, 1'b0, 1'b1},
        NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'hFF, 1'b0, 1'b0}, 1'b1, 1, '{8'h5E, 8'h00, 1'b1, 1'b1},
        NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'hA5, 1'b0, 1'b0}, 1'b1, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'h00, 1'b1, 1'b1}, 1'b1, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'hFF, 1'b0, 1'b0}, 1'b1, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'hFF, 1'b1, 1'b0}, 1'b1, 1, '{8'hF8, 8'h00, 1'b0, 1'b1},
        NO_SAMPLE},
      '{1'b0, 32'd3,          '{8'h03, 1'b0, 1'b1}, 1'b1, 1, '{8'hF0, 8'h00, 1'b0, 1'b1},
        NO_SAMPLE},
      '{1'b1, 32'd2,          '{8'hC3, 1'b1, 1'b0}, 1'b1, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b1, 32'd2,          '{8'h16, 1'b0, 1'b0}, 1'b1, 1, '{8'hC3, 8'h05, 1'b0, 1'b1},
        NO_SAMPLE},
      '{1'b1, 32'd2,          '{8'hFF, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b1, 32'd2,          '{8'hFF, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'hFFFF_FFFF,  '{8'h00, 1'b1, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'hFFFF_FFFF,  '{8'h00, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'hFFFF_FFFF,  '{8'h00, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'hFFFF_FFFF,  '{8'hFF, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'hFFFF_FFFF,  '{8'h80, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'hFFFF_FFFF,  '{8'h7F, 1'b0, 1'b1}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd1,          '{8'h02, 1'b1, 1'b0}, 1'b1, 1, '{8'h00, 8'h00, 1'b1, 1'b1},
        NO_SAMPLE},
      '{1'b0, 32'd10,         '{8'hC0, 1'b1, 1'b0}, 1'b1, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd10,         '{8'hF0, 1'b0, 1'b0}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE},
      '{1'b0, 32'd10,         '{8'h55, 1'b0, 1'b1}, 1'b0, 0, NO_SAMPLE, NO_SAMPLE}
   };

   // ------------------------------------------------------------------
   // Predictor of the decoder.
   // ------------------------------------------------------------------

   // A start byte, like reset, begins a fresh block: the delta and the sample
   // tally go back to zero and the next bit is the lead of a new code.
   function automatic void restart_block();
      dec_step      = DS_LEAD;
      dec_bits_left = 4'd0;
      dec_field     = 8'h00;
      dec_sign      = 1'b0;
      dec_run       = psdd_pkg::RUN_START;
      dec_low_hold  = 8'h00;
      dec_delta     = 8'h00;
      dec_done      = 32'd0;
   endfunction

   // Multi-bit fields arrive least significant bit first; the bit position is
   // how many bits of the field have already been taken.
   function automatic logic shift_in(input logic din, input logic [3:0] width);
      logic [2:0] pos;
      pos = 3'(width - dec_bits_left);
      dec_field = dec_field | (8'(din) << pos);
      if (dec_bits_left != 4'd0)
         dec_bits_left = dec_bits_left - 4'd1;
      return dec_bits_left == 4'd0;
   endfunction

   // A completed code: invert on a set sign, add into the running delta and lay
   // the sample out by the current mode.
   function automatic void close_sample(input logic [7:0] value);
      logic [7:0]        term;
      psdd_pkg::rsp_type s;
      term          = dec_sign ? (value ^ psdd_pkg::INVERT_MASK) : value;
      dec_delta     = dec_delta + term;
      s.sample_low   = cfg_wide ? dec_low_hold : dec_delta;
      s.sample_high  = cfg_wide ? dec_delta : 8'h00;
      s.final_sample = (dec_done + 32'd1 == cfg_count);
      s.last_of_item = 1'b0;
      fresh_samples.push_back(s);
      dec_done      = dec_done + 32'd1;
      dec_field     = 8'h00;
      dec_bits_left = 4'd0;
      dec_sign      = 1'b0;
      dec_run       = psdd_pkg::RUN_START;
      dec_step      = DS_LEAD;
   endfunction

   function automatic void decode_one_bit(input logic din);
      // The mode is looked at on the first bit of every code.
      if (dec_step == DS_LEAD) begin
         dec_field = 8'h00;
         if (cfg_wide) begin
            dec_step      = DS_LOW_BYTE;
            dec_bits_left = 4'd8;
         end else begin
            dec_step = DS_SIGN;
         end
      end
      case (dec_step)
         DS_LOW_BYTE: begin
            if (shift_in(din, 4'd8)) begin
               dec_low_hold = dec_field;
               dec_field    = 8'h00;
               dec_step     = DS_SIGN;
            end
         end
         DS_SIGN: begin
            dec_sign = din;
            dec_step = DS_FLAG;
         end
         DS_FLAG: begin
            dec_field = 8'h00;
            if (din) begin
               dec_step      = DS_SHORT;
               dec_bits_left = 4'd3;
            end else begin
               dec_step = DS_RUN;
               dec_run  = psdd_pkg::RUN_START;
            end
         end
         DS_SHORT: begin
            if (shift_in(din, 4'd3))
               close_sample(dec_field);
         end
         DS_RUN: begin
            if (din) begin
               dec_step      = DS_NIBBLE;
               dec_bits_left = 4'd4;
               dec_field     = 8'h00;
            end else begin
               dec_run = dec_run + psdd_pkg::RUN_STEP;
            end
         end
         DS_NIBBLE: begin
            if (shift_in(din, 4'd4))
               close_sample(dec_run + dec_field);
         end
         default: begin
         end
      endcase
   endfunction

   // Decodes one packed byte into fresh_samples. The return value tells whether
   // the byte reached the decoder at all, rather than being ignored after the
   // end mark or after the sample count was reached.
   function automatic logic predict_byte(input psdd_pkg::req_type item);
      logic live;
      fresh_samples.delete();
      if (item.start_flag)
         restart_block();
      live = (dec_step != DS_STOPPED) && (dec_done < cfg_count);
      for (int k = 0; k < 8; k++) begin
         if (dec_step == DS_STOPPED || dec_done >= cfg_count)
            break;
         decode_one_bit(item.packed_byte[k]);
      end
      if (item.end_of_data)
         dec_step = DS_STOPPED;
      if (fresh_samples.size() != 0)
         fresh_samples[fresh_samples.size() - 1].last_of_item = 1'b1;
      return live;
   endfunction

   // ------------------------------------------------------------------
   // Drivers. Every input changes only by nonblocking assignment at a rising
   // edge, so the decoder always sees stable values at the next edge.
   // ------------------------------------------------------------------

   // Offers one packed byte and returns at the edge where it was accepted. With
   // gaps enabled, valid sometimes drops for a short burst first. Between
   // back-to-back transactions valid simply stays high.
   task automatic offer_byte(input psdd_pkg::req_type item);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.packed_byte <= item.packed_byte;
      req_if.start_flag  <= item.start_flag;
      req_if.end_of_data <= item.end_of_data;
      bytes_offered++;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   // Drops valid, waits until every awaited sample has arrived, then gives a
   // byte that caused no sample time to leave the two-stage pipeline.
   task automatic wait_until_idle();
      req_if.valid <= 1'b0;
      while (awaited_samples.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // A register write drives the enable high for a single cycle; the enable then drops
   // before the task returns, so that back-to-back writes never drive it twice in one time step.
   task automatic write_register(input logic [psdd_pkg::CsrIndexWidth-1:0] index,
                                 input logic [31:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (index == psdd_pkg::CSR_WIDE_MODE)
         cfg_wide = value[0];
      else
         cfg_count = value;
      settings_written++;
      @(posedge clock);
   endtask

   // Accepts a byte, runs the predictor and queues what the decoder owes for it.
   task automatic send_and_predict(input psdd_pkg::req_type item);
      offer_byte(item);
      if (predict_byte(item))
         live_bytes++;
      foreach (fresh_samples[i])
         awaited_samples.push_back(fresh_samples[i]);
   endtask

   // ------------------------------------------------------------------
   // Receiver: ready drops in short bursts while gaps are enabled, and once,
   // on request, for a long stretch so the result FIFO fills and the decoder
   // has to stall its input.
   // ------------------------------------------------------------------
   initial begin : receiver
      int n;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            held_cycles += HoldOffCycles;
            rsp_if.ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sample checker: every sample transaction is compared field by field with
   // the oldest awaited sample. Values are read at the edge, before any
   // nonblocking update of that edge lands.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      psdd_pkg::rsp_type got;
      psdd_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.sample_low   = rsp_if.sample_low;
         got.sample_high  = rsp_if.sample_high;
         got.final_sample = rsp_if.final_sample;
         got.last_of_item = rsp_if.last_of_item;
         if (awaited_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected sample: low=%02h high=%02h final=%0b last=%0b",
                        got.sample_low, got.sample_high, got.final_sample,
                        got.last_of_item);
         end else begin
            want = awaited_samples.pop_front();
            samples_checked++;
            if (got.sample_low !== want.sample_low || got.sample_high !== want.sample_high
                || got.final_sample !== want.final_sample
                || got.last_of_item !== want.last_of_item) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"sample %0d: expected low=%02h high=%02h final=%0b last=%0b,",
                            " got low=%02h high=%02h final=%0b last=%0b"},
                           samples_checked, want.sample_low, want.sample_high,
                           want.final_sample, want.last_of_item, got.sample_low,
                           got.sample_high, got.final_sample, got.last_of_item);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: counts cycles without a transaction on either channel.
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d cycles without a transaction", StallLimit);
      $display("packed_sample_delta_decoder: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------
   initial begin : stimulus
      psdd_pkg::req_type item;
      logic              wide;
      logic [31:0]       count;
      int                phase_no;
      int                blocks;
      int                len;
      int                pick;
      bit                pressure;

      reset              <= 1'b1;
      csr_write_en       <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      req_if.valid       <= 1'b0;
      req_if.packed_byte <= 8'h00;
      req_if.start_flag  <= 1'b0;
      req_if.end_of_data <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      cfg_wide  = 1'b0;
      cfg_count = 32'd0;
      restart_block();

      // Directed part. A row whose setting differs from the current one first
      // lets the decoder go idle, then writes only the registers that change.
      for (int i = 0; i < DirectedRows; i++) begin
         if (directed_rows[i].wide !== cfg_wide || directed_rows[i].count !== cfg_count) begin
            wait_until_idle();
            if (directed_rows[i].wide !== cfg_wide)
               write_register(psdd_pkg::CSR_WIDE_MODE, 32'(directed_rows[i].wide));
            if (directed_rows[i].count !== cfg_count)
               write_register(psdd_pkg::CSR_SAMPLE_COUNT, directed_rows[i].count);
         end
         offer_byte(directed_rows[i].item);
         if (predict_byte(directed_rows[i].item))
            live_bytes++;
         if (directed_rows[i].typed) begin
            if (directed_rows[i].n >= 1)
               awaited_samples.push_back(directed_rows[i].first);
            if (directed_rows[i].n >= 2)
               awaited_samples.push_back(directed_rows[i].second);
         end else begin
            foreach (fresh_samples[i2])
               awaited_samples.push_back(fresh_samples[i2]);
         end
      end

      // Random part: phases, each with its own register setting, made of a few
      // blocks of random bytes. A block normally opens with a start byte and
      // mostly closes with an end mark; now and then a flag lands at random, and
      // the first block of a phase may carry on the previous phase's unfinished
      // code. Zero bytes are favored so that long runs wrap the run value. The
      // hold-off phase sends one long block with no stray flags, so the decoder
      // keeps producing samples until the result FIFO is full.
      phase_no = 0;
      while (bytes_offered < ItemTarget) begin
         wait_until_idle();
         pick = $urandom_range(0, 19);
         wide = 1'($urandom_range(0, 1));
         if (pick == 0)
            count = 32'd0;
         else if (pick == 1)
            count = 32'd1;
         else if (pick == 2)
            count = 32'hFFFF_FFFF;
         else if (pick == 3)
            count = $urandom();
         else
            count = $urandom_range(2, 48);
         gaps_on  = (bytes_offered < QuietFrom) && ($urandom_range(0, 3) != 0);
         pressure = (phase_no == 3);
         if (pressure) begin
            // The long receiver hold-off; the sender keeps going meanwhile.
            count            = 32'd200;
            gaps_on          = 1'b0;
            hold_off_request = 1'b1;
         end
         write_register(psdd_pkg::CSR_WIDE_MODE, 32'(wide));
         write_register(psdd_pkg::CSR_SAMPLE_COUNT, count);

         blocks = pressure ? 1 : $urandom_range(1, 4);
         for (int b = 0; b < blocks; b++) begin
            len = pressure ? 24 : $urandom_range(1, 24);
            for (int j = 0; j < len; j++) begin
               item.packed_byte = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom());
               item.start_flag  = (j == 0)
                                  && (pressure || !(b == 0 && $urandom_range(0, 3) == 0));
               if (!pressure && $urandom_range(0, 29) == 0)
                  item.start_flag = !item.start_flag;
               if (pressure)
                  item.end_of_data = (j == len - 1);
               else
                  item.end_of_data = (j == len - 1) ? ($urandom_range(0, 9) < 7)
                                                    : ($urandom_range(0, 39) == 0);
               send_and_predict(item);
            end
         end
         phase_no++;
      end

      // Drain: nothing more is offered; wait for the owed samples, then wait on
      // so that any stray sample that still arrives would be flagged.
      gaps_on = 1'b0;
      req_if.valid <= 1'b0;
      while (awaited_samples.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d packed bytes (%0d reached the decoder), %0d samples checked,",
               bytes_offered, live_bytes, samples_checked);
      $display("%0d register writes over %0d random phases, one %0d-cycle receiver hold-off",
               settings_written, phase_no, held_cycles);
      if (mismatch_count == 0) begin
         $display("packed_sample_delta_decoder: match");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("packed_sample_delta_decoder: mismatch");
      end
      $finish;
   end

endmodule
